>>> src/aufp_pkg.sv
// aufp_pkg: shared types and constants for the uncompressed alac frame packer
// no dependencies; used by aufp_stream_builder and alac_uncompressed_frame_packer

package aufp_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_FRAME_SAMPLES   = 2'd0;
   localparam logic [1:0] CSR_MONO_MODE       = 2'd1;
   localparam logic [1:0] CSR_HIGH_BYTE_FIRST = 2'd2;

   localparam int CSR_DATA_WIDTH = 13;
   localparam int COUNT_WIDTH    = 13;
   localparam int PENDING_WIDTH  = 7;
   localparam int STREAM_WIDTH   = 96;
   localparam int NBYTES_WIDTH   = 4;

   localparam logic [COUNT_WIDTH-1:0] FRAME_SAMPLES_RESET = 13'd352;
   localparam logic [COUNT_WIDTH-1:0] MAX_FRAME_SAMPLES   = 13'd4096;

   // 001 0000 000000000000 1 00 1
   localparam logic [22:0] HEADER_FLAGS = 23'h100009;
   localparam logic [2:0]  FOOTER_BITS  = 3'b111;

   // byte counts per request
   localparam logic [NBYTES_WIDTH-1:0] BYTES_MID        = 4'd4;
   localparam logic [NBYTES_WIDTH-1:0] BYTES_MID_CLOSE  = 4'd6;
   localparam logic [NBYTES_WIDTH-1:0] BYTES_OPEN       = 4'd10;
   localparam logic [NBYTES_WIDTH-1:0] BYTES_OPEN_CLOSE = 4'd12;

   typedef struct packed {
      logic [STREAM_WIDTH-1:0]  stream;
      logic [NBYTES_WIDTH-1:0]  nbytes;
      logic                     closes;
      logic [PENDING_WIDTH-1:0] pending;
   } build_type;

endpackage

>>> src/aufp_stream_builder.sv
// aufp_stream_builder: forms the left-justified bit stream for one request
// depends on aufp_pkg

module aufp_stream_builder (
   input  logic                              func,
   input  logic [7:0]                        byte_0,
   input  logic [7:0]                        byte_1,
   input  logic [7:0]                        byte_2,
   input  logic [7:0]                        byte_3,
   input  logic [aufp_pkg::COUNT_WIDTH-1:0]   frame_samples,
   input  logic                              mono_mode,
   input  logic                              high_byte_first,
   input  logic [aufp_pkg::COUNT_WIDTH-1:0]   sample_count,
   input  logic [aufp_pkg::PENDING_WIDTH-1:0] pending_bits,
   output aufp_pkg::build_type               build
);

   logic [aufp_pkg::COUNT_WIDTH-1:0] size;
   logic [7:0]                       rh;
   logic [7:0]                       rl_src;
   logic [31:0]                      word;
   logic                             opens;
   logic                             closes;
   logic [2:0]                       tail;

   always_comb begin
      // clamp frame size into 1..max
      if (frame_samples == '0) begin
         size = aufp_pkg::COUNT_WIDTH'(1);
      end else if (frame_samples > aufp_pkg::MAX_FRAME_SAMPLES) begin
         size = aufp_pkg::MAX_FRAME_SAMPLES;
      end else begin
         size = frame_samples;
      end

      // mono duplicates the left word into the right slot
      rh     = mono_mode ? byte_0 : byte_2;
      rl_src = mono_mode ? byte_1 : byte_3;
      if (high_byte_first) begin
         word = {byte_0, byte_1, rh, rl_src};
      end else begin
         word = {byte_1, byte_0, rl_src, rh};
      end
      if (func) begin
         word = '0;
      end

      opens  = (sample_count == '0);
      closes = ({1'b0, sample_count} + 14'd1) >= {1'b0, size};
      tail   = closes ? aufp_pkg::FOOTER_BITS : 3'b000;

      build.closes = closes;
      if (opens) begin
         build.stream  = {aufp_pkg::HEADER_FLAGS, 19'd0, size, word, tail, 6'd0};
         build.nbytes  = closes ? aufp_pkg::BYTES_OPEN_CLOSE : aufp_pkg::BYTES_OPEN;
         build.pending = build.stream[15:9];
      end else begin
         build.stream  = {pending_bits, word, tail, 54'd0};
         build.nbytes  = closes ? aufp_pkg::BYTES_MID_CLOSE : aufp_pkg::BYTES_MID;
         build.pending = build.stream[63:57];
      end
   end

endmodule

>>> src/alac_uncompressed_frame_packer.sv
// alac_uncompressed_frame_packer: packs 16-bit pcm sample frames into an
// uncompressed alac frame byte stream; depends on aufp_pkg, aufp_stream_builder
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_func, req_byte_0..req_byte_3
//   rsp      out  rsp_valid/rsp_stall  rsp_out_byte, rsp_last_of_run, rsp_frame_done
//   csr      in   csr_write_enable     csr_index, csr_data (no read-back)
//
// each request yields 4 bytes mid-frame, 10 when it opens a frame, 6 when it
// closes one and 12 when it does both; one byte leaves per cycle while rsp_stall
// is low, a rate set by the byte-wide rsp port
// a request is taken in the cycle the byte buffer hands its last byte to the
// output register, so requests follow each other with no gap
// reset is synchronous and active high; it clears the frame state and returns
// the config registers to their defaults
// rsp_stall holds the output register; the byte buffer then holds and, if it holds bytes, req stalls

module alac_uncompressed_frame_packer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_byte_0,
   input  logic [7:0]  req_byte_1,
   input  logic [7:0]  req_byte_2,
   input  logic [7:0]  req_byte_3,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,

   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [aufp_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   // configuration registers
   logic [aufp_pkg::COUNT_WIDTH-1:0] frame_samples_ff;
   logic                             mono_mode_ff;
   logic                             high_byte_first_ff;

   // frame state carried between requests
   logic [aufp_pkg::COUNT_WIDTH-1:0]   sample_count_ff, sample_count_in;
   logic [aufp_pkg::PENDING_WIDTH-1:0] pending_bits_ff, pending_bits_in;

   // byte buffer holding the bytes of one request, msb first
   logic                              buf_valid_ff, buf_valid_in;
   logic [aufp_pkg::STREAM_WIDTH-1:0] buf_data_ff, buf_data_in;
   logic [aufp_pkg::NBYTES_WIDTH-1:0] buf_left_ff, buf_left_in;
   logic                              buf_closes_ff, buf_closes_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;

   aufp_pkg::build_type build;

   logic req_accept;
   logic rsp_load;
   logic buf_last;

   aufp_stream_builder u_builder (
      .func            (req_func),
      .byte_0          (req_byte_0),
      .byte_1          (req_byte_1),
      .byte_2          (req_byte_2),
      .byte_3          (req_byte_3),
      .frame_samples   (frame_samples_ff),
      .mono_mode       (mono_mode_ff),
      .high_byte_first (high_byte_first_ff),
      .sample_count    (sample_count_ff),
      .pending_bits    (pending_bits_ff),
      .build           (build)
   );

   // output register takes a byte when empty or being drained
   assign rsp_load   = buf_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign buf_last   = (buf_left_ff == aufp_pkg::NBYTES_WIDTH'(1));
   // buffer free now, or freed by its last byte moving out this cycle
   assign req_stall  = buf_valid_ff && !(rsp_load && buf_last);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      sample_count_in = sample_count_ff;
      pending_bits_in = pending_bits_ff;
      buf_valid_in    = buf_valid_ff;
      buf_data_in     = buf_data_ff;
      buf_left_in     = buf_left_ff;
      buf_closes_in   = buf_closes_ff;

      if (req_accept) begin
         buf_valid_in  = 1'b1;
         buf_data_in   = build.stream;
         buf_left_in   = build.nbytes;
         buf_closes_in = build.closes;
         if (build.closes) begin
            sample_count_in = '0;
            pending_bits_in = '0;
         end else begin
            sample_count_in = sample_count_ff + aufp_pkg::COUNT_WIDTH'(1);
            pending_bits_in = build.pending;
         end
      end else if (rsp_load) begin
         buf_valid_in = !buf_last;
         buf_data_in  = {buf_data_ff[aufp_pkg::STREAM_WIDTH-9:0], 8'd0};
         buf_left_in  = buf_left_ff - aufp_pkg::NBYTES_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = buf_data_ff[aufp_pkg::STREAM_WIDTH-1 -: 8];
         rsp_last_in  = buf_last;
         rsp_done_in  = buf_last && buf_closes_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_samples_ff   <= aufp_pkg::FRAME_SAMPLES_RESET;
         mono_mode_ff       <= 1'b0;
         high_byte_first_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            aufp_pkg::CSR_FRAME_SAMPLES:   frame_samples_ff   <= csr_data;
            aufp_pkg::CSR_MONO_MODE:       mono_mode_ff       <= csr_data[0];
            aufp_pkg::CSR_HIGH_BYTE_FIRST: high_byte_first_ff <= csr_data[0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         pending_bits_ff <= '0;
         buf_valid_ff    <= 1'b0;
         buf_left_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sample_count_ff <= sample_count_in;
         pending_bits_ff <= pending_bits_in;
         buf_valid_ff    <= buf_valid_in;
         buf_left_ff     <= buf_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      buf_data_ff   <= buf_data_in;
      buf_closes_ff <= buf_closes_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_done  = rsp_done_ff;

   // a valid buffer always has bytes left to send
   a_buf_nonempty: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> buf_left_ff != '0)
      else $error("byte buffer valid with no bytes left");

   // frame done only on the last byte of a request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame done without last of run");

   // a request that opens a frame carries the header bytes
   a_open_bytes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && sample_count_ff == '0) |=>
         (buf_left_ff == aufp_pkg::BYTES_OPEN || buf_left_ff == aufp_pkg::BYTES_OPEN_CLOSE))
      else $error("frame open with wrong byte count");

   // sample count stays below the largest frame size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff < aufp_pkg::MAX_FRAME_SAMPLES)
      else $error("sample count out of range");

endmodule

>>> tb/tb_alac_uncompressed_frame_packer.sv
// tb_alac_uncompressed_frame_packer: self-checking bench for the uncompressed alac frame packer
// predicts the packed byte stream per request and checks every output byte in order
// depends on aufp_pkg and alac_uncompressed_frame_packer
`timescale 1ns / 100ps

module tb_alac_uncompressed_frame_packer;

   // header flag bits and footer of an uncompressed frame, msb first
   localparam logic [22:0] FRAME_FLAGS    = 23'h100009;
   localparam logic [2:0]  FRAME_FOOTER   = 3'b111;
   localparam int          FRAME_SIZE_MAX = 4096;

   localparam int TARGET_REQUESTS = 360;
   localparam int HOLD_CYCLES     = 200;
   localparam int DRAIN_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PAD_PCT         = 15;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
   } pcm_request_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last_of_run;
      logic       frame_done;
   } packed_byte_type;

   logic clock;
   logic reset = 1'b1;

   logic       req_valid  = 1'b0;
   logic       req_stall;
   logic       req_func   = 1'b0;
   logic [7:0] req_byte_0 = 8'h00;
   logic [7:0] req_byte_1 = 8'h00;
   logic [7:0] req_byte_2 = 8'h00;
   logic [7:0] req_byte_3 = 8'h00;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       rsp_frame_done;

   logic                                csr_write_enable = 1'b0;
   logic [1:0]                          csr_index        = aufp_pkg::CSR_FRAME_SAMPLES;
   logic [aufp_pkg::CSR_DATA_WIDTH-1:0] csr_data         = '0;

   alac_uncompressed_frame_packer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_byte_0       (req_byte_0),
      .req_byte_1       (req_byte_1),
      .req_byte_2       (req_byte_2),
      .req_byte_3       (req_byte_3),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // requests waiting to be driven, and bytes the packer still owes us
   pcm_request_type request_queue[$];
   packed_byte_type expected_bytes[$];

   // predictor copy of the packer's config and frame state
   logic [12:0] cfg_frame_samples;
   logic        cfg_mono;
   logic        cfg_high_byte_first;
   logic [6:0]  carry_bits;
   int unsigned frame_pos;

   // idle knobs, set per phase by the stimulus
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_requests = 0;

   bit          req_fire = 1'b0;
   bit          rsp_fire = 1'b0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned requests_taken = 0;
   int unsigned pads_taken = 0;
   int unsigned bytes_checked = 0;
   int unsigned frames_closed = 0;
   int unsigned csr_writes = 0;
   int unsigned input_stall_cycles = 0;

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(int unsigned idle_pct);
      if ($urandom_range(99) >= idle_pct)
         return 0;
      if ($urandom_range(9) == 0)
         return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   // works out the bytes one accepted request adds to the frame
   task automatic pack_sample(input pcm_request_type req);
      logic [95:0]     stream;
      logic [95:0]     shifted;
      logic [31:0]     size;
      logic [31:0]     word;
      logic [7:0]      right_hi_src;
      logic [7:0]      right_lo_src;
      int              nbits;
      int              nbytes;
      int              pad;
      bit              closes;
      packed_byte_type entry;

      // out-of-range sizes are clamped, and the clamped value goes into the header
      size = cfg_frame_samples;
      if (size == 0)
         size = 1;
      if (size > FRAME_SIZE_MAX)
         size = FRAME_SIZE_MAX;

      // a new frame starts with the 55-bit header, otherwise resume the carried bits
      if (frame_pos == 0) begin
         stream = {41'd0, FRAME_FLAGS, size};
         nbits  = 55;
      end else begin
         stream = {89'd0, carry_bits};
         nbits  = 7;
      end

      // mono copies the left channel to the right
      right_hi_src = cfg_mono ? req.byte_0 : req.byte_2;
      right_lo_src = cfg_mono ? req.byte_1 : req.byte_3;
      if (cfg_high_byte_first)
         word = {req.byte_0, req.byte_1, right_hi_src, right_lo_src};
      else
         word = {req.byte_1, req.byte_0, right_lo_src, right_hi_src};
      if (req.func)
         word = '0;
      stream = (stream << 32) | {64'd0, word};
      nbits  = nbits + 32;

      // closes also when the size was lowered below the running count
      closes = (frame_pos + 1) >= size;
      if (closes) begin
         stream     = (stream << 3) | {93'd0, FRAME_FOOTER};
         nbits      = nbits + 3;
         pad        = (8 - (nbits % 8)) % 8;
         stream     = stream << pad;
         nbits      = nbits + pad;
         frame_pos  = 0;
         carry_bits = '0;
      end else begin
         frame_pos  = frame_pos + 1;
         carry_bits = stream[6:0];
      end

      nbytes = nbits / 8;
      for (int i = 0; i < nbytes; i++) begin
         shifted           = stream >> (nbits - 8 * (i + 1));
         entry.value       = shifted[7:0];
         entry.last_of_run = (i == nbytes - 1);
         entry.frame_done  = closes && (i == nbytes - 1);
         expected_bytes.push_back(entry);
      end
      requests_taken++;
      if (req.func)
         pads_taken++;
   endtask

   // request driver: a new request goes out at the falling edge once the last one is taken
   int unsigned     req_gap_left = 0;
   pcm_request_type next_req;

   always @(negedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left = 0;
      end else if (!req_valid || req_fire) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            next_req = request_queue.pop_front();
            req_valid    <= 1'b1;
            req_func     <= next_req.func;
            req_byte_0   <= next_req.byte_0;
            req_byte_1   <= next_req.byte_1;
            req_byte_2   <= next_req.byte_2;
            req_byte_3   <= next_req.byte_3;
            req_gap_left = pick_gap(req_idle_pct);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random short and long stalls, plus the long hold when asked
   int unsigned rsp_stall_left = 0;
   int unsigned hold_seen = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen      = hold_requests;
         rsp_stall_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall_left = pick_gap(rsp_idle_pct);
         rsp_stall <= (rsp_stall_left > 0);
         if (rsp_stall_left > 0)
            rsp_stall_left--;
      end
   end

   // sampling at the rising edge: config writes, accepted requests, output bytes, watchdog
   packed_byte_type want;

   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         cfg_frame_samples   = aufp_pkg::FRAME_SAMPLES_RESET;
         cfg_mono            = 1'b0;
         cfg_high_byte_first = 1'b0;
         carry_bits          = '0;
         frame_pos           = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               aufp_pkg::CSR_FRAME_SAMPLES:   cfg_frame_samples = csr_data[12:0];
               aufp_pkg::CSR_MONO_MODE:       cfg_mono = csr_data[0];
               aufp_pkg::CSR_HIGH_BYTE_FIRST: cfg_high_byte_first = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (req_fire)
            pack_sample({req_func, req_byte_0, req_byte_1, req_byte_2, req_byte_3});
         if (rsp_fire) begin
            if (expected_bytes.size() == 0) begin
               if (mismatches < 10)
                  $display("[%0t] unexpected byte %02h last %0b done %0b", $realtime,
                           rsp_out_byte, rsp_last_of_run, rsp_frame_done);
               mismatches++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.value || rsp_last_of_run !== want.last_of_run ||
                   rsp_frame_done !== want.frame_done) begin
                  if (mismatches < 10)
                     $display("[%0t] byte mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                              $realtime, want.value, want.last_of_run, want.frame_done,
                              rsp_out_byte, rsp_last_of_run, rsp_frame_done);
                  mismatches++;
               end
               if (want.frame_done)
                  frames_closed++;
            end
            bytes_checked++;
         end
      end
      // nothing moving for too long means the packer is hung
      if (req_fire || rsp_fire || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic add_request(input logic func, input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
      request_queue.push_back({func, b0, b1, b2, b3});
   endtask

   task automatic add_random_requests(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         add_request($urandom_range(99) < PAD_PCT, 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
   endtask

   // register write at the falling edge, taken at the next rising edge
   task automatic csr_write(input logic [1:0] index,
                            input logic [aufp_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
   endtask

   // config may only change once every owed byte is out
   task automatic wait_idle();
      do
         @(posedge clock);
      while (request_queue.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   int unsigned queued = 0;
   int unsigned phase = 0;
   int unsigned count;
   int unsigned pick;

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-sample frames: every request opens and closes a frame, all-zero and
      // all-one bytes, alternating patterns, and a pad whose bytes must be ignored
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd1);
      csr_write(aufp_pkg::CSR_MONO_MODE, 13'd0);
      csr_write(aufp_pkg::CSR_HIGH_BYTE_FIRST, 13'd0);
      add_request(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      add_request(1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
      add_request(1'b0, 8'ha5, 8'h5a, 8'hc3, 8'h3c);
      add_request(1'b1, 8'hff, 8'hff, 8'hff, 8'hff);

      // size zero is taken as one; mono and big-endian input
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd0);
      csr_write(aufp_pkg::CSR_MONO_MODE, 13'd1);
      csr_write(aufp_pkg::CSR_HIGH_BYTE_FIRST, 13'd1);
      add_request(1'b0, 8'h12, 8'h34, 8'h56, 8'h78);
      add_request(1'b0, 8'hff, 8'h00, 8'haa, 8'h55);
      add_request(1'b1, 8'h80, 8'h01, 8'h80, 8'h01);

      // two back-to-back three-sample frames, stereo big-endian
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd3);
      csr_write(aufp_pkg::CSR_MONO_MODE, 13'd0);
      add_request(1'b0, 8'h01, 8'h80, 8'h7f, 8'hfe);
      add_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
      add_request(1'b0, 8'hfe, 8'h7f, 8'h80, 8'h01);
      add_request(1'b0, 8'h00, 8'hff, 8'h00, 8'hff);
      add_request(1'b0, 8'hff, 8'h00, 8'hff, 8'h00);
      add_request(1'b0, 8'h55, 8'haa, 8'h55, 8'haa);

      // size above the maximum is clamped, then the size is lowered mid-frame
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd8191);
      add_random_requests(3);
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd4096);
      add_random_requests(2);
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd2);
      add_random_requests(1);

      // modes changed between samples of one frame
      wait_idle();
      csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd4);
      csr_write(aufp_pkg::CSR_HIGH_BYTE_FIRST, 13'd0);
      add_request(1'b0, 8'h11, 8'h22, 8'h33, 8'h44);
      wait_idle();
      csr_write(aufp_pkg::CSR_MONO_MODE, 13'd1);
      add_request(1'b0, 8'h11, 8'h22, 8'h33, 8'h44);
      wait_idle();
      csr_write(aufp_pkg::CSR_HIGH_BYTE_FIRST, 13'd1);
      add_request(1'b0, 8'h11, 8'h22, 8'h33, 8'h44);
      wait_idle();
      csr_write(aufp_pkg::CSR_MONO_MODE, 13'd0);
      csr_write(aufp_pkg::CSR_HIGH_BYTE_FIRST, 13'd0);
      add_request(1'b0, 8'h11, 8'h22, 8'h33, 8'h44);
      queued = 23;

      // random phases: mostly short frames, now and then huge or out-of-range
      // sizes that the following phase cuts short
      while (queued < TARGET_REQUESTS) begin
         wait_idle();
         if ($urandom_range(4) != 0) begin
            pick = $urandom_range(99);
            if (pick < 55)
               csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'($urandom_range(6, 1)));
            else if (pick < 80)
               csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'($urandom_range(24, 7)));
            else if (pick < 88)
               csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd0);
            else if (pick < 94)
               csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'd4096);
            else
               csr_write(aufp_pkg::CSR_FRAME_SAMPLES, 13'($urandom_range(8191, 4097)));
         end
         if ($urandom_range(1))
            csr_write(aufp_pkg::CSR_MONO_MODE, 13'($urandom_range(1)));
         if ($urandom_range(1))
            csr_write(aufp_pkg::CSR_HIGH_BYTE_FIRST, 13'($urandom_range(1)));

         case ($urandom_range(2))
            0: req_idle_pct = 0;
            1: req_idle_pct = 20;
            default: req_idle_pct = 50;
         endcase
         case ($urandom_range(2))
            0: rsp_idle_pct = 0;
            1: rsp_idle_pct = 20;
            default: rsp_idle_pct = 50;
         endcase

         count = $urandom_range(40, 8);
         if (count > TARGET_REQUESTS - queued)
            count = TARGET_REQUESTS - queued;
         // third phase: the receiver holds off while the sender streams, so the
         // packer fills up and has to stall its input
         if (phase == 2) begin
            req_idle_pct = 0;
            count = 30;
         end
         add_random_requests(count);
         if (phase == 2)
            hold_requests++;
         queued += count;
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d requests (%0d pads), %0d frames closed, %0d bytes checked",
               requests_taken, pads_taken, frames_closed, bytes_checked);
      $display("%0d register writes over %0d random phases, input stalled %0d cycles",
               csr_writes, phase, input_stall_cycles);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d bytes still owed", mismatches, expected_bytes.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
src/aufp_pkg.sv
src/aufp_stream_builder.sv
src/alac_uncompressed_frame_packer.sv
tb/tb_alac_uncompressed_frame_packer.sv
